### rtl/psplit_pkg.sv
// shared types and constants for the proportional symbol split block
// used by psplit_div and proportional_symbol_split_top; no dependencies
package psplit_pkg;

	// field and accumulator widths
	localparam int BEAM_W     = 4;
	localparam int BYTES_W    = 32;
	localparam int SYM_W      = 8;
	localparam int BEAM_SUM_W = 40;
	localparam int TOTAL_W    = 44;
	localparam int PROD_W     = BEAM_SUM_W + SYM_W;
	localparam int STEP_W     = $clog2(SYM_W);
	localparam int USED_W     = 12;
	localparam int BEAM_SLOTS = 1 << BEAM_W;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_SHARE,
		ST_DIV,
		ST_LEFT,
		ST_MIN,
		ST_FILL,
		ST_OUT
	} psplit_state_t;

	// divider result toward the sequencer
	typedef struct packed {
		logic             done;
		logic [SYM_W-1:0] quo;
	} div_res_t;

endpackage

### rtl/psplit_div.sv
// restoring divider, one quotient bit per cycle, for the per-beam share
// depends on psplit_pkg; quotient is known to fit in SYM_W bits
module psplit_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [psplit_pkg::PROD_W-1:0]    dividend,
	input  logic [psplit_pkg::TOTAL_W-1:0]   divisor,
	output psplit_pkg::div_res_t             res
);
	import psplit_pkg::*;

	localparam int DIV_W = TOTAL_W + SYM_W;

	logic [PROD_W-1:0]  rem_q;
	logic [TOTAL_W-1:0] dvs_q;
	logic [STEP_W-1:0]  bit_q;
	logic [SYM_W-1:0]   quo_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_W-1:0]   shifted;
	logic [DIV_W-1:0]   rem_ext;
	logic [DIV_W-1:0]   diff;
	logic               fits;

	// trial subtract of the divisor at the current quotient bit
	always_comb begin
		shifted = DIV_W'(dvs_q) << bit_q;
		rem_ext = DIV_W'(rem_q);
		diff    = rem_ext - shifted;
		fits    = rem_ext >= shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= STEP_W'(SYM_W - 1);
				quo_q  <= '0;
			end else if (busy_q) begin
				if (fits) begin
					quo_q <= quo_q | (SYM_W'(1) << bit_q);
				end
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - STEP_W'(1);
				end
			end
		end
	end

	// partial remainder and divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q && fits) begin
			rem_q <= diff[PROD_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quo  = quo_q;

endmodule

### rtl/proportional_symbol_split_top.sv
// proportional symbol split: per-beam byte sums, proportional shares, leftover to fewest
// non-last request: accept, then accumulate; a last request then walks the beam slots to
// divide for each present beam with nonzero total (shared divider, one bit a cycle), scan
// for the minimum grant, fill the leftover level by level, and send grants with out stalls
// one request at a time; in_ready is high only while idle
// arst_n clears sequencer, present bits and total; byte and grant stores need no clearing
module proportional_symbol_split_top #(
	parameter int MAX_BEAMS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [psplit_pkg::BEAM_W-1:0]     beam_index,
	input  logic [psplit_pkg::BYTES_W-1:0]    ue_buffer_bytes,
	input  logic [psplit_pkg::SYM_W-1:0]      symbols_available,
	input  logic                              last_user,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [psplit_pkg::BEAM_W-1:0]     beam_out,
	output logic [psplit_pkg::SYM_W-1:0]      beam_symbols,
	output logic                              last_grant
);
	import psplit_pkg::*;

	// beam slots beyond the index range can never be addressed
	localparam int NB = (MAX_BEAMS > BEAM_SLOTS) ? BEAM_SLOTS : MAX_BEAMS;
	localparam int IW = $clog2(NB);

	psplit_state_t state_q, state_d;

	logic [BEAM_W-1:0]     beam_q;
	logic [BYTES_W-1:0]    bytes_q;
	logic [SYM_W-1:0]      syms_q;
	logic                  last_q;

	logic [IW-1:0]         idx_q;
	logic [NB-1:0]         present_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [USED_W-1:0]     used_q;
	logic [SYM_W-1:0]      left_q;
	logic [SYM_W-1:0]      min_q;

	logic [BEAM_SUM_W-1:0] bytes_mem [NB];
	logic [SYM_W-1:0]      grant_mem [NB];

	logic                  out_valid_q;
	logic [BEAM_W-1:0]     beam_out_q;
	logic [SYM_W-1:0]      symbols_q;
	logic                  last_grant_q;

	logic                  div_start;
	div_res_t              div_res;

	logic                  beam_ok;
	logic [IW-1:0]         acc_idx;
	logic [IW-1:0]         rd_idx;
	logic [BEAM_SUM_W-1:0] rd_bytes;
	logic [BEAM_SUM_W-1:0] old_bytes;
	logic [BEAM_SUM_W:0]   beam_sum;
	logic [BEAM_SUM_W-1:0] new_beam;
	logic [TOTAL_W:0]      tot_sum;
	logic [TOTAL_W-1:0]    new_total;
	logic [PROD_W-1:0]     product;
	logic [SYM_W-1:0]      grant_rd;
	logic                  idx_last;
	logic [IW-1:0]         idx_next;
	logic                  cur_present;
	logic [USED_W-1:0]     used_next;
	logic [SYM_W-1:0]      left_calc;
	logic                  fill_hit;
	logic [SYM_W-1:0]      min_nxt;
	logic                  more_above;
	logic                  out_load;

	// shared read port and accumulate arithmetic
	always_comb begin
		beam_ok     = {1'b0, beam_q} < (BEAM_W + 1)'(NB);
		acc_idx     = beam_q[IW-1:0];
		rd_idx      = (state_q == ST_ACC) ? acc_idx : idx_q;
		rd_bytes    = bytes_mem[rd_idx];
		old_bytes   = present_q[rd_idx] ? rd_bytes : '0;
		beam_sum    = {1'b0, old_bytes} + (BEAM_SUM_W + 1)'(bytes_q);
		new_beam    = beam_sum[BEAM_SUM_W] ? '1 : beam_sum[BEAM_SUM_W-1:0];
		tot_sum     = {1'b0, total_q} + (TOTAL_W + 1)'(bytes_q);
		new_total   = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
		product     = PROD_W'(rd_bytes) * PROD_W'(syms_q);
		grant_rd    = grant_mem[idx_q];
		cur_present = present_q[idx_q];
		idx_last    = idx_q == IW'(NB - 1);
		idx_next    = idx_last ? '0 : idx_q + IW'(1);
		used_next   = used_q + USED_W'(div_res.quo);
		left_calc   = ((|present_q) && (used_q < USED_W'(syms_q)))
			? SYM_W'(USED_W'(syms_q) - used_q) : '0;
		fill_hit    = cur_present && (grant_rd == min_q);
		min_nxt     = (cur_present && (grant_rd < min_q)) ? grant_rd : min_q;
		out_load    = (state_q == ST_OUT) && cur_present && (!out_valid_q || out_ready);
	end

	// any present beam above the current slot
	always_comb begin
		more_above = 1'b0;
		for (int j = 0; j < NB; j++) begin
			if (present_q[j] && (IW'(j) > idx_q)) begin
				more_above = 1'b1;
			end
		end
	end

	// sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = last_q ? ST_SHARE : ST_IDLE;
			end
			ST_SHARE: begin
				if (cur_present && (total_q != '0)) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else if (idx_last) begin
					state_d = ST_LEFT;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = idx_last ? ST_LEFT : ST_SHARE;
				end
			end
			ST_LEFT: begin
				state_d = (left_calc == '0) ? ST_OUT : ST_MIN;
			end
			ST_MIN: begin
				if (idx_last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (fill_hit && (left_q == SYM_W'(1))) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if ((!cur_present || out_load) && idx_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers: present bits, sums, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			present_q <= '0;
			total_q   <= '0;
			used_q    <= '0;
			left_q    <= '0;
			min_q     <= '0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (beam_ok) begin
						present_q[acc_idx] <= 1'b1;
						total_q            <= new_total;
					end
					idx_q  <= '0;
					used_q <= '0;
				end
				ST_SHARE: begin
					if (!(cur_present && (total_q != '0))) begin
						idx_q <= idx_next;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						used_q <= used_next;
						idx_q  <= idx_next;
					end
				end
				ST_LEFT: begin
					left_q <= left_calc;
					min_q  <= '1;
					idx_q  <= '0;
				end
				ST_MIN: begin
					min_q <= min_nxt;
					idx_q <= idx_next;
				end
				ST_FILL: begin
					if (fill_hit) begin
						left_q <= left_q - SYM_W'(1);
					end
					if (fill_hit && (left_q == SYM_W'(1))) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_next;
						if (idx_last) begin
							min_q <= min_q + SYM_W'(1);
						end
					end
				end
				ST_OUT: begin
					if (!cur_present || out_load) begin
						idx_q <= idx_next;
						if (idx_last) begin
							present_q <= '0;
							total_q   <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request capture and per-beam stores
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beam_q  <= beam_index;
			bytes_q <= ue_buffer_bytes;
			syms_q  <= symbols_available;
			last_q  <= last_user;
		end
		if ((state_q == ST_ACC) && beam_ok) begin
			bytes_mem[acc_idx] <= new_beam;
		end
		if ((state_q == ST_SHARE) && cur_present && (total_q == '0)) begin
			grant_mem[idx_q] <= '0;
		end
		if ((state_q == ST_DIV) && div_res.done) begin
			grant_mem[idx_q] <= div_res.quo;
		end
		if ((state_q == ST_FILL) && fill_hit) begin
			grant_mem[idx_q] <= grant_rd + SYM_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			beam_out_q   <= BEAM_W'(idx_q);
			symbols_q    <= grant_rd;
			last_grant_q <= !more_above;
		end
	end

	psplit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (total_q),
		.res      (div_res)
	);

	assign out_valid    = out_valid_q;
	assign beam_out     = beam_out_q;
	assign beam_symbols = symbols_q;
	assign last_grant   = last_grant_q;

	// block holds off a second request while one is in work
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// a nonzero total needs at least one present beam
	a_total_present: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != '0) |-> (present_q != '0))
		else $error("total without present beam");

	// divider results only land during the share phase
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider done outside share phase");

	// fill phase always has symbols left
	a_fill_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (left_q != '0))
		else $error("fill phase with nothing left");

endmodule
